// File: sv/spe_pkg.sv
// ----------------------------------------------------------------------------
// spe_pkg
// Shared types and constants of the shortest path engine.
// ----------------------------------------------------------------------------
package spe_pkg;

    localparam int NODE_BITS      = 6;
    localparam int STRIDE         = 1 << NODE_BITS;
    localparam int EDGE_ADDR_BITS = 2 * NODE_BITS;
    localparam int DIST_OUT_BITS  = 22;
    localparam logic [DIST_OUT_BITS-1:0] DIST_OUT_MAX = 22'h3FFFFF;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_PATH = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_CHK,
        ST_ADD_WR2,
        ST_QINIT,
        ST_SCAN,
        ST_PICK,
        ST_RELAX,
        ST_TRACE_RD,
        ST_TRACE_WAIT,
        ST_EMIT_RD,
        ST_EMIT_LOAD,
        ST_NOT_FOUND
    } state_t;

    typedef struct packed {
        logic [NODE_BITS-1:0]     path_node;
        logic [DIST_OUT_BITS-1:0] distance;
        logic                     found;
        logic                     last;
    } result_t;

endpackage

// File: sv/spe_ram.sv
// ----------------------------------------------------------------------------
// spe_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module spe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/spe_outreg.sv
// ----------------------------------------------------------------------------
// spe_outreg
// Result output register with valid/ready handshake.
// ----------------------------------------------------------------------------
module spe_outreg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  spe_pkg::result_t  data,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [5:0]        path_node,
    output logic [21:0]       distance,
    output logic              found,
    output logic              last
);
    import spe_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign out_valid = valid_reg;
    assign path_node = data_reg.path_node;
    assign distance  = data_reg.distance;
    assign found     = data_reg.found;
    assign last      = data_reg.last;

endmodule

// File: sv/shortest_path_engine_unit.sv
// ----------------------------------------------------------------------------
// shortest_path_engine_unit
// Dijkstra shortest path engine on an undirected weighted graph.
// ----------------------------------------------------------------------------
// After reset the edge memory is swept clear, one entry a cycle, across all
// 4096 entries before the first transaction is taken. An add-edge transaction
// reads the edge entry, checks it and, if the edge is new, writes both
// directions. A query runs in rounds: every round scans the node memory for
// the minimum and then the edge row of the node just settled, one entry a
// cycle through the single read port of each; the final round scans only,
// the path trace reads the predecessor of each path node back to the source,
// and the result stream emits one result per path node while results drain.
// ----------------------------------------------------------------------------
module shortest_path_engine_unit #(
    parameter int NODES       = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [5:0]  node_a,
    input  logic [5:0]  node_b,
    input  logic [15:0] weight,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  path_node,
    output logic [21:0] distance,
    output logic        found,
    output logic        last
);
    import spe_pkg::*;

    localparam int DW = WEIGHT_BITS + NODE_BITS;
    localparam int CW = (DW > DIST_OUT_BITS) ? DW : DIST_OUT_BITS;
    localparam int NW = DW + NODE_BITS;

    state_t state_reg, state_next;

    logic [EDGE_ADDR_BITS-1:0] clr_reg, clr_next;
    logic [NODE_BITS-1:0]      a_reg, a_next;
    logic [NODE_BITS-1:0]      b_reg, b_next;
    logic [WEIGHT_BITS-1:0]    w_reg, w_next;
    logic [NODE_BITS:0]        cnt_reg, cnt_next;
    logic                      rv_reg, rv_next;
    logic [NODE_BITS-1:0]      idx_reg, idx_next;
    logic                      pick_ok_reg, pick_ok_next;
    logic [NODE_BITS-1:0]      pick_reg, pick_next;
    logic [DW-1:0]             pick_dist_reg, pick_dist_next;
    logic [STRIDE-1:0]         present_reg, present_next;
    logic [STRIDE-1:0]         settled_reg, settled_next;
    logic [STRIDE-1:0]         reached_reg, reached_next;
    logic [NODE_BITS-1:0]      cur_reg, cur_next;
    logic [NODE_BITS:0]        len_reg, len_next;

    logic                      edge_we, edge_re;
    logic [EDGE_ADDR_BITS-1:0] edge_waddr, edge_raddr;
    logic [WEIGHT_BITS:0]      edge_wdata, edge_rdata;
    logic                      node_we, node_re;
    logic [NODE_BITS-1:0]      node_waddr, node_raddr;
    logic [NW-1:0]             node_wdata, node_rdata;
    logic                      path_we, path_re;
    logic [NODE_BITS-1:0]      path_waddr, path_raddr, path_wdata, path_rdata;

    logic                      out_load, out_free;
    result_t                   out_data;

    logic                      in_ok;
    logic [DW-1:0]             node_dist;
    logic [NODE_BITS-1:0]      node_pred;
    logic [DW-1:0]             nd;
    logic [NODE_BITS:0]        len_m1;
    logic                      len_one;
    logic [DIST_OUT_BITS-1:0]  dist_out;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_ok     = ({1'b0, node_a} < (NODE_BITS + 1)'(NODES))
                    && ({1'b0, node_b} < (NODE_BITS + 1)'(NODES));
    assign node_dist = node_rdata[DW-1:0];
    assign node_pred = node_rdata[DW +: NODE_BITS];
    assign nd        = pick_dist_reg + DW'(edge_rdata[WEIGHT_BITS-1:0]);
    assign len_m1    = len_reg - 1'b1;
    assign len_one   = (len_reg == (NODE_BITS + 1)'(1));
    assign dist_out  = (CW'(pick_dist_reg) > CW'(DIST_OUT_MAX)) ? DIST_OUT_MAX
                                                               : DIST_OUT_BITS'(pick_dist_reg);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        w_next         = w_reg;
        cnt_next       = cnt_reg;
        rv_next        = rv_reg;
        idx_next       = idx_reg;
        pick_ok_next   = pick_ok_reg;
        pick_next      = pick_reg;
        pick_dist_next = pick_dist_reg;
        present_next   = present_reg;
        settled_next   = settled_reg;
        reached_next   = reached_reg;
        cur_next       = cur_reg;
        len_next       = len_reg;

        edge_we    = 1'b0;
        edge_waddr = {a_reg, b_reg};
        edge_wdata = {1'b1, w_reg};
        edge_re    = 1'b0;
        edge_raddr = {a_reg, b_reg};
        node_we    = 1'b0;
        node_waddr = idx_reg;
        node_wdata = {pick_reg, nd};
        node_re    = 1'b0;
        node_raddr = cnt_reg[NODE_BITS-1:0];
        path_we    = 1'b0;
        path_waddr = len_reg[NODE_BITS-1:0];
        path_wdata = cur_reg;
        path_re    = 1'b0;
        path_raddr = len_m1[NODE_BITS-1:0];
        out_load   = 1'b0;
        out_data   = '{path_node: '0, distance: '0, found: 1'b0, last: 1'b1};

        case (state_reg)
            ST_CLEAR:
            begin
                edge_we    = 1'b1;
                edge_waddr = clr_reg;
                edge_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    a_next = node_a;
                    b_next = node_b;
                    w_next = WEIGHT_BITS'(weight);
                    if (!in_ok)
                    begin
                        state_next = (func == FUNC_PATH) ? ST_NOT_FOUND : ST_IDLE;
                    end
                    else if (func == FUNC_ADD)
                    begin
                        state_next = ST_ADD_RD;
                    end
                    else if (present_reg[node_a] && present_reg[node_b])
                    begin
                        state_next = ST_QINIT;
                    end
                    else
                    begin
                        state_next = ST_NOT_FOUND;
                    end
                end
            end
            ST_ADD_RD:
            begin
                edge_re    = 1'b1;
                state_next = ST_ADD_CHK;
            end
            ST_ADD_CHK:
            begin
                if (edge_rdata[WEIGHT_BITS])
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    edge_we             = 1'b1;
                    present_next[a_reg] = 1'b1;
                    present_next[b_reg] = 1'b1;
                    state_next          = ST_ADD_WR2;
                end
            end
            ST_ADD_WR2:
            begin
                edge_we    = 1'b1;
                edge_waddr = {b_reg, a_reg};
                state_next = ST_IDLE;
            end
            ST_QINIT:
            begin
                node_we             = 1'b1;
                node_waddr          = a_reg;
                node_wdata          = '0;
                settled_next        = '0;
                reached_next        = '0;
                reached_next[a_reg] = 1'b1;
                cnt_next            = '0;
                rv_next             = 1'b0;
                pick_ok_next        = 1'b0;
                state_next          = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (cnt_reg < (NODE_BITS + 1)'(NODES))
                begin
                    node_re  = 1'b1;
                    idx_next = cnt_reg[NODE_BITS-1:0];
                    rv_next  = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    rv_next    = 1'b0;
                    state_next = ST_PICK;
                end
                if (rv_reg && reached_reg[idx_reg] && !settled_reg[idx_reg]
                    && (!pick_ok_reg || (node_dist < pick_dist_reg)))
                begin
                    pick_ok_next   = 1'b1;
                    pick_next      = idx_reg;
                    pick_dist_next = node_dist;
                end
            end
            ST_PICK:
            begin
                if (!pick_ok_reg)
                begin
                    state_next = ST_NOT_FOUND;
                end
                else
                begin
                    settled_next[pick_reg] = 1'b1;
                    if (pick_reg == b_reg)
                    begin
                        cur_next   = b_reg;
                        len_next   = '0;
                        state_next = ST_TRACE_RD;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        rv_next    = 1'b0;
                        state_next = ST_RELAX;
                    end
                end
            end
            ST_RELAX:
            begin
                if (cnt_reg < (NODE_BITS + 1)'(NODES))
                begin
                    edge_re    = 1'b1;
                    edge_raddr = {pick_reg, cnt_reg[NODE_BITS-1:0]};
                    node_re    = 1'b1;
                    idx_next   = cnt_reg[NODE_BITS-1:0];
                    rv_next    = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                end
                else
                begin
                    rv_next      = 1'b0;
                    cnt_next     = '0;
                    pick_ok_next = 1'b0;
                    state_next   = ST_SCAN;
                end
                if (rv_reg && edge_rdata[WEIGHT_BITS]
                    && (!reached_reg[idx_reg] || (nd < node_dist)))
                begin
                    node_we               = 1'b1;
                    reached_next[idx_reg] = 1'b1;
                end
            end
            ST_TRACE_RD:
            begin
                node_re    = 1'b1;
                node_raddr = cur_reg;
                path_we    = 1'b1;
                len_next   = len_reg + 1'b1;
                state_next = (cur_reg == a_reg) ? ST_EMIT_RD : ST_TRACE_WAIT;
            end
            ST_TRACE_WAIT:
            begin
                cur_next   = node_pred;
                state_next = ST_TRACE_RD;
            end
            ST_EMIT_RD:
            begin
                path_re    = 1'b1;
                state_next = ST_EMIT_LOAD;
            end
            ST_EMIT_LOAD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_data   = '{path_node: path_rdata, distance: dist_out,
                                   found: 1'b1, last: len_one};
                    len_next   = len_m1;
                    state_next = len_one ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_NOT_FOUND:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            present_reg <= '0;
            rv_reg      <= 1'b0;
            pick_ok_reg <= 1'b0;
            cnt_reg     <= '0;
            len_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            present_reg <= present_next;
            rv_reg      <= rv_next;
            pick_ok_reg <= pick_ok_next;
            cnt_reg     <= cnt_next;
            len_reg     <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        w_reg         <= w_next;
        idx_reg       <= idx_next;
        pick_reg      <= pick_next;
        pick_dist_reg <= pick_dist_next;
        settled_reg   <= settled_next;
        reached_reg   <= reached_next;
        cur_reg       <= cur_next;
    end

    spe_ram #(
        .WIDTH (WEIGHT_BITS + 1),
        .DEPTH (1 << EDGE_ADDR_BITS)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .re    (edge_re),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    spe_ram #(
        .WIDTH (NW),
        .DEPTH (STRIDE)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    spe_ram #(
        .WIDTH (NODE_BITS),
        .DEPTH (STRIDE)
    ) u_path_ram (
        .clk   (clk),
        .we    (path_we),
        .waddr (path_waddr),
        .wdata (path_wdata),
        .re    (path_re),
        .raddr (path_raddr),
        .rdata (path_rdata)
    );

    spe_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .data      (out_data),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .path_node (path_node),
        .distance  (distance),
        .found     (found),
        .last      (last)
    );

    a_relax_unsettled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RELAX && node_we) |-> !settled_reg[idx_reg])
        else $error("relaxation wrote a settled node");

    a_pick_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PICK && pick_ok_reg)
        |-> (reached_reg[pick_reg] && !settled_reg[pick_reg]))
        else $error("picked node is unreached or already settled");

    a_trace_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TRACE_RD) |-> (len_reg < (NODE_BITS + 1)'(NODES)))
        else $error("path trace longer than node count");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result loaded over a pending transaction");

endmodule
